// ===== rtl/lwst_pkg.sv =====
// Shared types and constants for the windowed latency statistics block.
`default_nettype none
package lwst_pkg;

	// Field widths
	localparam int TS_W       = 63;
	localparam int DEV_W      = 48;
	localparam int DIFF_W     = 50;
	localparam int EXP_W      = 32;
	localparam int WLEN_W     = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN     = 1'd1;

	// Register reset values
	localparam logic [EXP_W-1:0]  EXP_RESET  = 32'd20000000;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd50;

	// Saturation limits: raw interval to +/-2^48, deviation to +/-(2^47-1)
	localparam logic signed [DIFF_W-1:0] DIFF_LIM = {2'b01, {(DIFF_W-2){1'b0}}};
	localparam logic signed [DEV_W-1:0]  DEV_MAX  = {1'b0, {(DEV_W-1){1'b1}}};

	// k = L - L*9/10 = ceil(L/10) = (L + 9) / 10, divided by reciprocal
	localparam int PCT_DEN = 10;
	localparam logic [16:0] RECIP10 = 17'd52429;
	localparam int RECIP10_SH = 19;

	// Input beat
	typedef struct packed {
		logic [TS_W-1:0] start_time;
		logic [TS_W-1:0] end_time;
	} samp_t;

	// Output beat
	typedef struct packed {
		logic signed [DEV_W-1:0] mean_dev;
		logic signed [DEV_W-1:0] min_dev;
		logic signed [DEV_W-1:0] max_dev;
		logic signed [DEV_W-1:0] topk_dev;
	} stat_t;

	// One slot of the top-k row
	typedef struct packed {
		logic                    vld;
		logic signed [DEV_W-1:0] val;
	} entry_t;

	// Control broadcast to every cell of the row
	typedef struct packed {
		logic                    ins;
		logic                    win_end;
		logic                    shift;
		logic signed [DEV_W-1:0] dev;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lwst_cell.sv =====
// One cell of the sorted top-k row, with its snapshot slot.
`default_nettype none
module lwst_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lwst_pkg::cell_ctl_t ctl,
	input  logic               prv_ge,
	input  lwst_pkg::entry_t    prv,
	input  lwst_pkg::entry_t    nxt_snap,
	output logic               ge,
	output lwst_pkg::entry_t    ent,
	output lwst_pkg::entry_t    snap
);

	logic                              ent_vld_q;
	logic signed [lwst_pkg::DEV_W-1:0] ent_val_q;
	logic                              snap_vld_q;
	logic signed [lwst_pkg::DEV_W-1:0] snap_val_q;
	lwst_pkg::entry_t                  ent_nx;

	// Keep the slot if it holds a value at least as large; ties stay in front
	assign ge = ent_vld_q && (ent_val_q >= ctl.dev);

	// Keep, take the new deviation, or take the neighbor's entry
	always_comb begin
		priority if (ge) begin
			ent_nx.vld = ent_vld_q;
			ent_nx.val = ent_val_q;
		end else if (prv_ge) begin
			ent_nx.vld = 1'b1;
			ent_nx.val = ctl.dev;
		end else begin
			ent_nx = prv;
		end
	end

	// Valid bits: drop the row at window end, snapshot moves toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= 1'b0;
			snap_vld_q <= 1'b0;
		end else if (ctl.ins) begin
			if (ctl.win_end) begin
				snap_vld_q <= ent_nx.vld;
				ent_vld_q  <= 1'b0;
			end else begin
				ent_vld_q <= ent_nx.vld;
			end
		end else if (ctl.shift) begin
			snap_vld_q <= nxt_snap.vld;
		end
	end

	// Values
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (ctl.win_end) begin
				snap_val_q <= ent_nx.val;
			end else begin
				ent_val_q <= ent_nx.val;
			end
		end else if (ctl.shift) begin
			snap_val_q <= nxt_snap.val;
		end
	end

	assign ent.vld  = ent_vld_q;
	assign ent.val  = ent_val_q;
	assign snap.vld = snap_vld_q;
	assign snap.val = snap_val_q;

endmodule
`default_nettype wire

// ===== rtl/lwst_fin.sv =====
// Window finisher: bit-serial mean divider, top-k readout and output register.
`default_nettype none
module lwst_fin #(
	parameter int SUM_W = 58,
	parameter int CNT_W = 11,
	parameter int K_W   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic signed [SUM_W-1:0]           sum,
	input  logic [CNT_W-1:0]                  cnt,
	input  logic signed [lwst_pkg::DEV_W-1:0] min,
	input  logic signed [lwst_pkg::DEV_W-1:0] max,
	input  logic [K_W-1:0]                    kd,
	input  lwst_pkg::entry_t                   head,
	input  logic                              more,
	output logic                              shift,
	output logic                              busy,
	output logic                              stat_valid,
	input  logic                              stat_stall,
	output lwst_pkg::stat_t                    stat
);

	localparam int UW   = SUM_W - 1;
	localparam int DC_W = $clog2(UW + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t                            state_q;
	logic [DC_W-1:0]                   div_cnt_q;
	logic [UW-1:0]                     quo_q;
	logic [CNT_W-1:0]                  rem_q;
	logic [CNT_W-1:0]                  dvs_q;
	logic                              neg_q;
	logic [K_W-1:0]                    kd_q;
	logic signed [lwst_pkg::DEV_W-1:0] min_q;
	logic signed [lwst_pkg::DEV_W-1:0] max_q;
	logic                              stat_valid_q;
	lwst_pkg::stat_t                   stat_q;

	logic [SUM_W-1:0]                  sum_mag;
	logic [CNT_W:0]                    trial;
	logic [CNT_W:0]                    trial_sub;
	logic [lwst_pkg::DEV_W-1:0]        quo_lo;

	// Magnitude of the window sum; sign restored at the end
	assign sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

	// One restoring step per cycle
	assign trial     = {rem_q, quo_q[UW-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign quo_lo    = quo_q[lwst_pkg::DEV_W-1:0];

	// Walk the snapshot row toward the head until the k-th entry sits there
	assign shift = (state_q == ST_RUN) && (kd_q != '0) && more;
	assign busy  = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			stat_valid_q <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			if (stat_valid_q && !stat_stall && state_q != ST_DONE) begin
				stat_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						quo_q     <= sum_mag[UW-1:0];
						rem_q     <= '0;
						dvs_q     <= cnt;
						neg_q     <= sum[SUM_W-1];
						kd_q      <= kd;
						min_q     <= min;
						max_q     <= max;
						div_cnt_q <= DC_W'(UW);
						state_q   <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (div_cnt_q != '0) begin
						if (!trial_sub[CNT_W]) begin
							rem_q <= trial_sub[CNT_W-1:0];
							quo_q <= {quo_q[UW-2:0], 1'b1};
						end else begin
							rem_q <= trial[CNT_W-1:0];
							quo_q <= {quo_q[UW-2:0], 1'b0};
						end
						div_cnt_q <= div_cnt_q - 1'b1;
					end
					if (shift) begin
						kd_q <= kd_q - 1'b1;
					end
					if (div_cnt_q == '0 && !shift) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (!stat_valid_q || !stat_stall) begin
						stat_q.mean_dev <= neg_q ? -$signed(quo_lo) : $signed(quo_lo);
						stat_q.min_dev  <= min_q;
						stat_q.max_dev  <= max_q;
						stat_q.topk_dev <= head.vld ? head.val : '0;
						stat_valid_q    <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat_valid = stat_valid_q;
	assign stat       = stat_q;

endmodule
`default_nettype wire

// ===== rtl/latency_window_stats_topk_top.sv =====
// Top level of the windowed latency statistics block with top-k store.
//
//  Channel | Direction | Handshake           | Beat
//  samp    | in        | samp_valid/stall    | start_time, end_time
//  stat    | out       | stat_valid/stall    | mean_dev, min_dev, max_dev, topk_dev
//  cfg     | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// One sample enters per cycle while samp is not stalled; it passes the stage-1 and
// stage-2 registers before it reaches the top-k cell row. The last sample of a
// window starts the finisher, which stalls samp while the bit-serial mean divider
// runs and the snapshot row shifts; a full stat register adds wait.
// Reset clears the window, the cell valid bits and the handshakes; config regs
// return to expected_delay = 20000000 and window_len = 50.
`default_nettype none
module latency_window_stats_topk_top #(
	parameter int TOP_DEPTH  = 128,
	parameter int MAX_WINDOW = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 samp_valid,
	output logic                                 samp_stall,
	input  lwst_pkg::samp_t                       samp,
	output logic                                 stat_valid,
	input  logic                                 stat_stall,
	output lwst_pkg::stat_t                       stat,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lwst_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lwst_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int LEN_W = (CNT_W > lwst_pkg::WLEN_W) ? CNT_W : lwst_pkg::WLEN_W;
	localparam int SUM_W = lwst_pkg::DEV_W + $clog2(MAX_WINDOW);
	localparam int K_W   = $clog2(TOP_DEPTH + 1);
	localparam int KX_W  = CNT_W + 1;
	localparam int PW    = KX_W + 17;

	// Configuration
	logic [lwst_pkg::EXP_W-1:0]  exp_q;
	logic [lwst_pkg::WLEN_W-1:0] wlen_q;

	// Front pipeline
	logic                               vld_s1;
	logic signed [lwst_pkg::DIFF_W-1:0] diff_s1;
	logic                               vld_s2;
	logic signed [lwst_pkg::DEV_W-1:0]  dev_s2;
	logic signed [63:0]                 raw_diff;
	logic signed [lwst_pkg::DIFF_W:0]   dly_diff;

	// Window accumulators
	logic signed [SUM_W-1:0]           sum_q;
	logic signed [lwst_pkg::DEV_W-1:0] min_q;
	logic signed [lwst_pkg::DEV_W-1:0] max_q;
	logic [CNT_W-1:0]                  cnt_q;

	logic                              adv;
	logic                              upd;
	logic                              win_end;
	logic signed [SUM_W-1:0]           sum_nx;
	logic signed [lwst_pkg::DEV_W-1:0] min_nx;
	logic signed [lwst_pkg::DEV_W-1:0] max_nx;
	logic [CNT_W-1:0]                  cnt_nx;
	logic [LEN_W-1:0]                  wlen_x;
	logic [CNT_W-1:0]                  len_eff;
	logic [KX_W-1:0]                   k_x;
	logic [PW-1:0]                     k_prod;
	logic [KX_W-1:0]                   k_raw;
	logic [K_W-1:0]                    kd;

	// Cell row links
	lwst_pkg::cell_ctl_t ctl;
	logic                ge_c   [TOP_DEPTH+1];
	lwst_pkg::entry_t    ent_c  [TOP_DEPTH+1];
	lwst_pkg::entry_t    snap_c [TOP_DEPTH+1];
	logic [TOP_DEPTH:0]  row_vld;

	logic fin_busy;
	logic fin_shift;

	// Config writes; any time is fine, the user keeps them to idle periods
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= lwst_pkg::EXP_RESET;
			wlen_q <= lwst_pkg::WLEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lwst_pkg::CFG_EXPECTED_DELAY: exp_q  <= cfg_data[lwst_pkg::EXP_W-1:0];
				lwst_pkg::CFG_WINDOW_LEN:     wlen_q <= cfg_data[lwst_pkg::WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipe advances only while the finisher is idle
	assign adv        = !fin_busy;
	assign samp_stall = fin_busy;

	// Stage 1: interval, saturated to +/-2^48
	assign raw_diff = $signed({1'b0, samp.end_time}) - $signed({1'b0, samp.start_time});

	// Stage 2: subtract the nominal delay, saturate to +/-(2^47-1)
	assign dly_diff = (lwst_pkg::DIFF_W+1)'(diff_s1)
		- $signed({{(lwst_pkg::DIFF_W+1-lwst_pkg::EXP_W){1'b0}}, exp_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= samp_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (raw_diff > 64'(lwst_pkg::DIFF_LIM)) begin
				diff_s1 <= lwst_pkg::DIFF_LIM;
			end else if (raw_diff < -64'(lwst_pkg::DIFF_LIM)) begin
				diff_s1 <= -lwst_pkg::DIFF_LIM;
			end else begin
				diff_s1 <= raw_diff[lwst_pkg::DIFF_W-1:0];
			end
			if (dly_diff > (lwst_pkg::DIFF_W+1)'(lwst_pkg::DEV_MAX)) begin
				dev_s2 <= lwst_pkg::DEV_MAX;
			end else if (dly_diff < -(lwst_pkg::DIFF_W+1)'(lwst_pkg::DEV_MAX)) begin
				dev_s2 <= -lwst_pkg::DEV_MAX;
			end else begin
				dev_s2 <= dly_diff[lwst_pkg::DEV_W-1:0];
			end
		end
	end

	// Effective window length: zero counts as one, clamp to the maximum
	assign wlen_x = LEN_W'(wlen_q);

	always_comb begin
		priority if (wlen_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (wlen_x > LEN_W'(MAX_WINDOW)) begin
			len_eff = CNT_W'(MAX_WINDOW);
		end else begin
			len_eff = CNT_W'(wlen_x);
		end
	end

	// k = ceil(len/10), clamped to the row depth; kept as k-1
	assign k_x    = KX_W'(len_eff) + KX_W'(lwst_pkg::PCT_DEN - 1);
	assign k_prod = PW'(k_x) * PW'(lwst_pkg::RECIP10);
	assign k_raw  = KX_W'(k_prod >> lwst_pkg::RECIP10_SH);
	assign kd     = (int'(k_raw) > TOP_DEPTH) ? K_W'(TOP_DEPTH - 1) : K_W'(k_raw - 1'b1);

	// Stage 3: fold the deviation into the window
	assign upd     = vld_s2 && adv;
	assign sum_nx  = sum_q + SUM_W'(dev_s2);
	assign min_nx  = (dev_s2 < min_q) ? dev_s2 : min_q;
	assign max_nx  = (dev_s2 > max_q) ? dev_s2 : max_q;
	assign cnt_nx  = cnt_q + 1'b1;
	assign win_end = (cnt_nx >= len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= lwst_pkg::DEV_MAX;
			max_q <= '0;
			cnt_q <= '0;
		end else if (upd) begin
			if (win_end) begin
				sum_q <= '0;
				min_q <= lwst_pkg::DEV_MAX;
				max_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_nx;
				min_q <= min_nx;
				max_q <= max_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	// Top-k cell row: head has no neighbor in front, tail none behind
	assign ctl.ins     = upd;
	assign ctl.win_end = win_end;
	assign ctl.shift   = fin_shift;
	assign ctl.dev     = dev_s2;

	assign ge_c[0]             = 1'b1;
	assign ent_c[0]            = '0;
	assign snap_c[TOP_DEPTH]   = '0;
	assign row_vld[TOP_DEPTH]  = 1'b0;

	for (genvar i = 0; i < TOP_DEPTH; i++) begin : g_cell
		lwst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prv_ge   (ge_c[i]),
			.prv      (ent_c[i]),
			.nxt_snap (snap_c[i+1]),
			.ge       (ge_c[i+1]),
			.ent      (ent_c[i+1]),
			.snap     (snap_c[i])
		);
		assign row_vld[i] = ent_c[i+1].vld;
	end

	// Window finisher
	lwst_fin #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W),
		.K_W   (K_W)
	) u_fin (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (upd && win_end),
		.sum        (sum_nx),
		.cnt        (cnt_nx),
		.min        (min_nx),
		.max        (max_nx),
		.kd         (kd),
		.head       (snap_c[0]),
		.more       (snap_c[1].vld),
		.shift      (fin_shift),
		.busy       (fin_busy),
		.stat_valid (stat_valid),
		.stat_stall (stat_stall),
		.stat       (stat)
	);

	// Valid entries of the row always form a prefix from the head
	a_row_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(row_vld + 1'b1))
		else $error("top-k row has a gap");

	// A finished window leaves the row empty
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		upd && win_end |=> row_vld == '0)
		else $error("top-k row not cleared at window end");

	// A finished window holds off new samples while the finisher works
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upd && win_end |=> samp_stall)
		else $error("sample accepted while window finishes");

endmodule
`default_nettype wire
